// ===== hdl/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and codes of the table linear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tli_pkg;

  // operation code carried in s_axis_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // result status carried in m_axis_tuser
  localparam logic [2:0] STATUS_INTERP = 3'd0;
  localparam logic [2:0] STATUS_BELOW  = 3'd1;
  localparam logic [2:0] STATUS_ABOVE  = 3'd2;
  localparam logic [2:0] STATUS_ZERO   = 3'd3;
  localparam logic [2:0] STATUS_SAT    = 3'd4;

  localparam logic [31:0] Y_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Y_MIN = 32'h8000_0000;

  localparam logic [7:0] POINTS_RESET = 8'd20;

  // quotient bits left after the overflow pre-check
  localparam int DIV_STEPS = 33;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_CHECK,
    S_SCAN,
    S_FETCH,
    S_FETCH2,
    S_DIFF,
    S_MAG,
    S_MULT,
    S_OVF,
    S_DIV,
    S_ADD,
    S_DONE
  } state_t;

  // magnitude of a 33-bit signed difference of two 32-bit values
  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] n;
    n = 33'd0 - v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/table_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear lookup over a loadable breakpoint table, Q16.16 values.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser is the operation. A load transaction writes
// (x, y) into slot point_index and gives no result; slots at or beyond
// TABLE_DEPTH are dropped. An evaluate transaction gives one result on
// m_axis: y_result in tdata, status in tuser.
// An evaluate runs the range checks, then k table x reads of the linear
// segment scan, one RAM read per cycle, where k runs from 0 to the clamped
// point count minus 2, then the segment fetch, the multiply and the
// bit-serial divider, one quotient bit per cycle; zero-step and overflow
// cases finish sooner. s_axis_tready is low while an evaluate is in flight
// and high otherwise. points_in_use is written through cfg_wr_en /
// cfg_wr_data, by the user only while idle; the block does not enforce it.
// A result waits in the output register while m_axis_tready is low; new
// loads and evaluates are still accepted, and a second finished evaluate
// holds in its last step until the register frees up.
// Reset (rst, synchronous) clears the sequencer and output valid and sets
// points_in_use to 20; the table contents are kept and must be loaded
// before use.
// ----------------------------------------------------------------------------
`default_nettype none

module table_linear_interpolator #(
  parameter int TABLE_DEPTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [6:0] point_index, [38:7] x_value, [70:39] y_value, [71] zero
  input  wire logic [71:0] s_axis_tdata,
  // [0] operation
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] y_result
  output logic      [31:0] m_axis_tdata,
  // [2:0] status
  output logic      [2:0]  m_axis_tuser
);

  import tli_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  state_t state, state_next;

  logic [7:0]  points_in_use;

  logic [6:0]  in_index;
  logic [31:0] in_x;
  logic [31:0] in_y;
  logic        accept;
  logic        load_wr;
  logic [31:0] idx_ext;
  logic [31:0] piu_ext;
  logic [AW-1:0] last_in;

  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_x;
  logic [31:0]   rd_y;

  // working registers
  logic signed [31:0] x_q;
  logic [AW-1:0]      last_idx;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      seg;
  logic               below;
  logic [2:0]         range_status;
  logic [31:0]        xa;
  logic [31:0]        ya;
  logic [32:0]        dx;
  logic [32:0]        dy;
  logic [32:0]        ex;
  logic [31:0]        dxm;
  logic [31:0]        dym;
  logic [31:0]        exm;
  logic               neg;
  logic [63:0]        prod;
  logic [31:0]        rem;
  logic [32:0]        qd;
  logic [CNT_W-1:0]   cnt;
  logic [31:0]        res_y;
  logic [2:0]         res_status;

  logic               x_lt_rd;
  logic               div_ovf;
  logic [32:0]        div_t;
  logic               div_ge;
  logic [32:0]        div_diff;
  logic [34:0]        sum;
  logic               out_load;

  assign in_index = s_axis_tdata[6:0];
  assign in_x     = s_axis_tdata[38:7];
  assign in_y     = s_axis_tdata[70:39];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign idx_ext = 32'(in_index);
  assign load_wr = accept && (s_axis_tuser[0] == OP_LOAD) && (idx_ext < 32'(TABLE_DEPTH));

  // clamp the point count to [2, TABLE_DEPTH] and keep the last index
  assign piu_ext = 32'(points_in_use);
  always_comb begin
    priority if (piu_ext < 32'd2) begin
      last_in = AW'(1);
    end else if (piu_ext > 32'(TABLE_DEPTH)) begin
      last_in = AW'(TABLE_DEPTH - 1);
    end else begin
      last_in = AW'(piu_ext - 32'd1);
    end
  end

  tli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_x_ram (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (AW'(idx_ext)),
    .wr_data (in_x),
    .rd_addr (rd_addr),
    .rd_data (rd_x)
  );

  tli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_y_ram (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (AW'(idx_ext)),
    .wr_data (in_y),
    .rd_addr (rd_addr),
    .rd_data (rd_y)
  );

  assign x_lt_rd = x_q < $signed(rd_x);
  assign div_ovf = {1'b0, prod[63:33]} >= dxm;
  assign div_t    = {rem, qd[32]};
  assign div_ge   = div_t >= {1'b0, dxm};
  assign div_diff = div_t - {1'b0, dxm};
  assign sum = neg ? ({{3{ya[31]}}, ya} - {2'b00, qd})
                   : ({{3{ya[31]}}, ya} + {2'b00, qd});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = '0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && (s_axis_tuser[0] == OP_EVAL)) begin
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        rd_addr    = '0;
        state_next = S_LAST;
      end
      S_LAST: begin
        rd_addr    = last_idx;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        rd_addr = idx;
        if (below || !x_lt_rd || (last_idx == AW'(1))) begin
          state_next = S_FETCH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr = idx + AW'(1);
        if (x_lt_rd || (idx == last_idx - AW'(1))) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        rd_addr    = seg;
        state_next = S_FETCH2;
      end
      S_FETCH2: begin
        rd_addr    = seg + AW'(1);
        state_next = S_DIFF;
      end
      S_DIFF: begin
        state_next = S_MAG;
      end
      S_MAG: begin
        state_next = (dx == 33'd0) ? S_DONE : S_MULT;
      end
      S_MULT: begin
        state_next = S_OVF;
      end
      S_OVF: begin
        state_next = div_ovf ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (cnt == '0) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= POINTS_RESET;
    end else if (cfg_wr_en) begin
      points_in_use <= cfg_wr_data;
    end
  end

  // datapath registers, advanced by the sequencer state
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        x_q      <= $signed(in_x);
        last_idx <= last_in;
      end
      S_LAST: begin
        below <= x_lt_rd;
        idx   <= AW'(1);
      end
      S_CHECK: begin
        priority if (below) begin
          seg          <= '0;
          range_status <= STATUS_BELOW;
        end else if (!x_lt_rd) begin
          seg          <= last_idx - AW'(1);
          range_status <= STATUS_ABOVE;
        end else begin
          seg          <= '0;
          range_status <= STATUS_INTERP;
        end
      end
      S_SCAN: begin
        priority if (x_lt_rd) begin
          seg <= idx - AW'(1);
        end else if (idx == last_idx - AW'(1)) begin
          seg <= last_idx - AW'(1);
        end else begin
          idx <= idx + AW'(1);
        end
      end
      S_FETCH2: begin
        xa <= rd_x;
        ya <= rd_y;
      end
      S_DIFF: begin
        dx <= {rd_x[31], rd_x} - {xa[31], xa};
        dy <= {rd_y[31], rd_y} - {ya[31], ya};
        ex <= {x_q[31], x_q} - {xa[31], xa};
      end
      S_MAG: begin
        dxm <= mag33(dx);
        dym <= mag33(dy);
        exm <= mag33(ex);
        neg <= ex[32] ^ dy[32] ^ dx[32];
        if (dx == 33'd0) begin
          res_y      <= ya;
          res_status <= STATUS_ZERO;
        end
      end
      S_MULT: begin
        prod <= 64'(exm) * 64'(dym);
      end
      S_OVF: begin
        // quotient of 2^33 or more saturates whatever ya is
        if (div_ovf) begin
          res_y      <= neg ? Y_MIN : Y_MAX;
          res_status <= STATUS_SAT;
        end
        rem <= {1'b0, prod[63:33]};
        qd  <= prod[32:0];
        cnt <= CNT_W'(DIV_STEPS - 1);
      end
      S_DIV: begin
        rem <= div_ge ? div_diff[31:0] : div_t[31:0];
        qd  <= {qd[31:0], div_ge};
        cnt <= cnt - CNT_W'(1);
      end
      S_ADD: begin
        priority if (!sum[34] && (sum[33:31] != 3'b000)) begin
          res_y      <= Y_MAX;
          res_status <= STATUS_SAT;
        end else if (sum[34] && (sum[33:31] != 3'b111)) begin
          res_y      <= Y_MIN;
          res_status <= STATUS_SAT;
        end else begin
          res_y      <= sum[31:0];
          res_status <= range_status;
        end
      end
      default: begin
      end
    endcase
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= res_y;
      m_axis_tuser <= res_status;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tli_ram.sv =====
// ----------------------------------------------------------------------------
// tli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/tli_checker.sv =====
// ----------------------------------------------------------------------------
// tli_checker
// Port-level assertions for the table linear interpolator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [0:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  import tli_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // an evaluate transaction blocks the input in the next cycle
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_EVAL) |=> !s_axis_tready)
    else $error("input ready right after an evaluate");

  // a load never makes a result appear
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_LOAD) && !m_axis_tvalid
      |=> !m_axis_tvalid)
    else $error("result after a load");

  // a saturated result sits at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == STATUS_SAT)
      |-> (m_axis_tdata == Y_MAX) || (m_axis_tdata == Y_MIN))
    else $error("saturated status off the limits");

endmodule

bind table_linear_interpolator tli_checker u_tli_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_table_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// tb_table_linear_interpolator
// Self-checking testbench for the breakpoint table interpolator.
// ----------------------------------------------------------------------------
// Load and evaluate transactions go in on s_axis. A local copy of the table
// and of points_in_use predicts each lookup result in full precision, with
// truncation and 32-bit saturation. A monitor checks every m_axis
// transaction against the oldest prediction. Directed tests hit the segment
// search, range extension, zero step, rounding, saturation and the point
// count limits. Random phases reload small tables of several shapes and query
// them under random source gaps and sink stalls. One phase holds the sink off
// long enough for the block to stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_table_linear_interpolator;
  timeunit 1ns;
  timeprecision 1ps;

  import tli_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam int IDLE_SETTLE = 8;
  localparam int END_SETTLE  = 200;   // longer than the slowest lookup
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [31:0] y_result;
    logic [2:0]  status;
  } lookup_result_t;

  typedef enum int {
    TBL_WIDE,
    TBL_NARROW,
    TBL_STEEP,
    TBL_REPEAT_X,
    TBL_SHUFFLED
  } table_shape_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // [6:0] point_index, [38:7] x, [70:39] y
  logic [0:0]  s_axis_tuser = '0;   // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [31:0] m_axis_tdata;        // [31:0] y_result
  logic [2:0]  m_axis_tuser;        // [2:0] status

  logic [31:0]    x_shadow [TABLE_DEPTH];
  logic [31:0]    y_shadow [TABLE_DEPTH];
  logic [7:0]     points_cfg = POINTS_RESET;
  lookup_result_t pending_lookups [$];

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_off_cycles = 0;
  int error_count = 0;
  int items_sent = 0;
  int loads_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int status_seen [5] = '{default: 0};

  table_linear_interpolator #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $error("timeout with %0d lookups outstanding", pending_lookups.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint as_q16(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic int unsigned effective_points();
    if (points_cfg < 2) return 2;
    if (points_cfg > TABLE_DEPTH) return TABLE_DEPTH;
    return points_cfg;
  endfunction

  function automatic lookup_result_t predict_lookup(input logic [31:0] qx);
    lookup_result_t r;
    int unsigned    n, seg;
    longint         x, xa, xb, ya, yb, dx, dy, ex, yw, qv;
    logic [127:0]   prod, quo;
    logic           neg;
    n = effective_points();
    x = as_q16(qx);
    if (x < as_q16(x_shadow[0])) begin
      seg = 0;
      r.status = STATUS_BELOW;
    end else if (x >= as_q16(x_shadow[n - 1])) begin
      seg = n - 2;
      r.status = STATUS_ABOVE;
    end else begin
      r.status = STATUS_INTERP;
      seg = 0;
      while (seg < n - 2 && x >= as_q16(x_shadow[seg + 1])) seg++;
    end
    xa = as_q16(x_shadow[seg]);
    xb = as_q16(x_shadow[seg + 1]);
    ya = as_q16(y_shadow[seg]);
    yb = as_q16(y_shadow[seg + 1]);
    dx = xb - xa;
    dy = yb - ya;
    if (dx == 0) begin
      r.y_result = y_shadow[seg];
      r.status = STATUS_ZERO;
      return r;
    end
    ex = x - xa;
    neg = ((ex < 0) != (dy < 0)) != (dx < 0);
    prod = 128'(magnitude(ex)) * 128'(magnitude(dy));
    if (prod == 0) begin
      yw = ya;
    end else begin
      quo = prod / 128'(magnitude(dx));
      // quotient too wide: push far out of range so the clamp below fires
      if (quo[127:34] != 0) begin
        yw = neg ? -64'sh100_0000_0000 : 64'sh100_0000_0000;
      end else begin
        qv = longint'(quo[63:0]);
        yw = neg ? ya - qv : ya + qv;
      end
    end
    if (yw > 64'sd2147483647) begin
      r.y_result = Y_MAX;
      r.status = STATUS_SAT;
    end else if (yw < -64'sd2147483648) begin
      r.y_result = Y_MIN;
      r.status = STATUS_SAT;
    end else begin
      r.y_result = yw[31:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------- source and sink

  task automatic send_item(input logic op, input logic [6:0] slot,
                           input logic [31:0] xv, input logic [31:0] yv);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, yv, xv, slot};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (op == OP_LOAD) begin
      x_shadow[slot] = xv;
      y_shadow[slot] = yv;
      loads_sent++;
    end else begin
      pending_lookups.push_back(predict_lookup(xv));
    end
  endtask

  task automatic load_point(input logic [6:0] slot, input logic [31:0] xv,
                            input logic [31:0] yv);
    send_item(OP_LOAD, slot, xv, yv);
  endtask

  // slot and y ride along unused on an evaluate
  task automatic evaluate_at(input logic [31:0] xv);
    send_item(OP_EVAL, 7'($urandom), xv, $urandom);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_point_count(input logic [7:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    points_cfg = value;
    cfg_writes++;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        m_axis_tready <= 1'b0;
        while (hold_off_cycles > 0) begin
          @(posedge clk);
          hold_off_cycles--;
        end
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_lookups.size() == 0) begin
        $error("unexpected result: y_result %h status %0d", m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (m_axis_tdata !== want.y_result) begin
          $error("y_result mismatch: expected %h, got %h", want.y_result, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, m_axis_tuser);
          error_count++;
        end
        results_checked++;
        if (want.status <= STATUS_SAT) status_seen[want.status]++;
      end
    end
  end

  // ------------------------------------------------------- table generation

  task automatic load_random_table(input int unsigned n, input table_shape_t shape);
    logic [31:0] xs [$];
    logic [31:0] ys [$];
    int unsigned order [$];
    longint      base;
    int unsigned span, pos, k, i;
    logic [31:0] v, w;
    span = 1 << $urandom_range(2, 24);
    base = -64'sd2147483648
           + longint'({32'b0, $urandom}) % (64'sd4294967296 - longint'(span));
    for (i = 0; i < n; i++) begin
      if (shape == TBL_NARROW || shape == TBL_STEEP)
        v = 32'(base + longint'($urandom_range(0, span)));
      else
        v = $urandom;
      if (shape == TBL_SHUFFLED) begin
        xs.push_back(v);
      end else begin
        pos = 0;
        while (pos < xs.size() && as_q16(xs[pos]) <= as_q16(v)) pos++;
        xs.insert(pos, v);
      end
      w = $urandom;
      ys.push_back(shape == TBL_NARROW ? {{12{w[19]}}, w[19:0]} : w);
      order.push_back(i);
    end
    if (shape == TBL_REPEAT_X) begin
      k = $urandom_range(1, n - 1);
      xs[k] = xs[k - 1];
    end
    // load the slots in random order
    while (order.size() != 0) begin
      k = $urandom_range(0, order.size() - 1);
      load_point(7'(order[k]), xs[order[k]], ys[order[k]]);
      order.delete(k);
    end
  endtask

  function automatic logic [31:0] pick_query(input int unsigned n);
    longint      a, b, lo, hi;
    int unsigned r, seg;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      seg = $urandom_range(0, n - 2);
      a = as_q16(x_shadow[seg]);
      b = as_q16(x_shadow[seg + 1]);
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return 32'(lo + longint'({32'b0, $urandom}) % (hi - lo + 1));
    end
    if (r < 7) return x_shadow[$urandom_range(0, n - 1)];
    if (r == 7)
      return ($urandom_range(0, 1) != 0) ? x_shadow[0] - 32'd1 : x_shadow[n - 1] + 32'd1;
    return $urandom;
  endfunction

  task automatic run_table_phase();
    int unsigned  pick, n, lookups, j;
    logic [7:0]   count_value;
    table_shape_t shape;
    pick = $urandom_range(0, 99);
    if (pick < 70)      count_value = 8'($urandom_range(2, 10));
    else if (pick < 82) count_value = 8'($urandom_range(11, 40));
    else if (pick < 90) count_value = 8'($urandom_range(0, 1));
    else if (pick < 95) count_value = 8'(TABLE_DEPTH);
    else                count_value = 8'($urandom_range(TABLE_DEPTH + 1, 255));
    write_point_count(count_value);
    n = effective_points();
    pick = $urandom_range(0, 9);
    if (pick < 5)       shape = TBL_WIDE;
    else if (pick < 7)  shape = TBL_NARROW;
    else if (pick == 7) shape = TBL_STEEP;
    else if (pick == 8) shape = TBL_REPEAT_X;
    else                shape = TBL_SHUFFLED;
    if (n <= 40) begin
      load_random_table(n, shape);
    end else begin
      // large tables stay mostly as they are; touch a few slots
      repeat (6) load_point(7'($urandom), $urandom, $urandom);
    end
    lookups = $urandom_range(6, 16);
    for (j = 0; j < lookups; j++) begin
      if ($urandom_range(0, 9) == 0)
        load_point(7'($urandom_range(0, n - 1)), $urandom, $urandom);
      else
        evaluate_at(pick_query(n));
    end
  endtask

  // ------------------------------------------------------------------- tests

  task automatic test_reset_point_count();
    int unsigned j;
    gap_pct = 20;
    stall_pct = 20;
    load_random_table(POINTS_RESET, TBL_WIDE);
    for (j = 0; j < 4; j++) evaluate_at(pick_query(POINTS_RESET));
    wait_idle();
  endtask

  task automatic test_segment_search();
    write_point_count(8'd3);
    load_point(7'd0, 32'hffff_0000, 32'h0000_0000);
    load_point(7'd1, 32'h0001_0000, 32'h0002_0000);
    load_point(7'd2, 32'h0003_0000, 32'h0001_0000);
    evaluate_at(32'h0000_0000);   // inside the first segment
    evaluate_at(32'h0001_0000);   // on the middle point: second segment
    evaluate_at(32'hfffe_0000);   // below the table
    evaluate_at(32'h0003_0000);   // on the last point
    evaluate_at(32'h7fff_ffff);
    evaluate_at(32'h8000_0000);
  endtask

  task automatic test_zero_step_and_rounding();
    load_point(7'd0, 32'd0, 32'd0);
    load_point(7'd1, 32'd3, 32'hffff_fffe);
    load_point(7'd2, 32'd3, 32'd5);
    evaluate_at(32'd2);           // -4/3 truncates to -1
    evaluate_at(32'd3);           // last segment has no x step
    evaluate_at(32'hffff_fffe);   // extend below: 4/3 truncates to 1
  endtask

  task automatic test_unsorted_and_saturation();
    load_point(7'd0, 32'd0, 32'h7fff_0000);
    load_point(7'd1, 32'd1, 32'h7fff_ffff);
    load_point(7'd2, 32'hffff_fffb, 32'h9000_0000);   // last x below the first
    evaluate_at(32'd0);
    evaluate_at(32'h7fff_ffff);   // quotient overflows
    evaluate_at(32'h8000_0000);   // negative overflow
    evaluate_at(32'd2);           // sum leaves the 32-bit range
    wait_idle();
  endtask

  task automatic test_point_count_extremes();
    int unsigned k;
    logic [7:0]  counts [6] = '{8'd128, 8'd255, 8'd200, 8'd0, 8'd1, 8'd2};
    load_random_table(TABLE_DEPTH, TBL_WIDE);
    for (k = 0; k < 6; k++) begin
      write_point_count(counts[k]);
      evaluate_at(pick_query(effective_points()));
      evaluate_at(x_shadow[effective_points() - 1]);
    end
  endtask

  task automatic test_output_backpressure();
    int unsigned j;
    write_point_count(8'd4);
    load_random_table(4, TBL_WIDE);
    wait_idle();
    gap_pct = 0;
    hold_off_cycles = LONG_HOLD;
    // keep offering while the sink is held off so the input stalls
    for (j = 0; j < 8; j++) begin
      if (j % 3 == 2) load_point(7'($urandom_range(0, 3)), $urandom, $urandom);
      else evaluate_at(pick_query(4));
    end
    wait_idle();
  endtask

  task automatic test_random_traffic(input int goal);
    int pcts [3] = '{0, 15, 40};
    while (items_sent < goal) begin
      gap_pct = pcts[$urandom_range(0, 2)];
      stall_pct = pcts[$urandom_range(0, 2)];
      run_table_phase();
    end
  endtask

  task automatic test_back_to_back(input int goal);
    gap_pct = 0;
    stall_pct = 0;
    while (items_sent < goal) run_table_phase();
  endtask

  initial begin
    int guard;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_point_count();
    test_segment_search();
    test_zero_step_and_rounding();
    test_unsorted_and_saturation();
    test_point_count_extremes();
    test_output_backpressure();
    test_random_traffic(660);
    test_back_to_back(750);

    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pending_lookups.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (END_SETTLE) @(posedge clk);
    if (pending_lookups.size() != 0) begin
      $error("%0d lookups never came back", pending_lookups.size());
      error_count++;
    end

    $display("Sent %0d transactions (%0d table loads, %0d point-count writes).",
             items_sent, loads_sent, cfg_writes);
    $display("Checked %0d lookups: %0d inside, %0d below, %0d above, %0d zero step, %0d saturated.",
             results_checked, status_seen[STATUS_INTERP], status_seen[STATUS_BELOW],
             status_seen[STATUS_ABOVE], status_seen[STATUS_ZERO], status_seen[STATUS_SAT]);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
